// ----- rtl/assert_macros.svh -----
// assert_macros.svh: assertion helpers shared by the region veto RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CRVB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("region veto assertion failed");
// Condition that must never be seen outside reset.
`define CRVB_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("region veto forbidden condition seen");
`else
`define CRVB_ASSERT(lbl, clk, rst_n, prop)
`define CRVB_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/crvb_pkg.sv -----
// crvb_pkg: widths, register codes, stage types and the strip pattern check
// for the region veto block. No dependencies.
package crvb_pkg;

    // Field widths.
    localparam int ET_W      = 10;
    localparam int PCT_W     = 7;
    localparam int IDX_W     = 2;
    localparam int POS_W     = 4;
    localparam int STRIP_W   = 4;
    localparam int CNT_W     = 5;
    localparam int CNT_MAX   = 31;

    // Saturation limit of the ET sums and the widths that follow from it.
    localparam int ET_LIMIT  = 1023;
    localparam int SUM_W     = $clog2(ET_LIMIT + 1);
    localparam int ADD_W     = ((SUM_W > ET_W) ? SUM_W : ET_W) + 1;

    // Percent scaling: x > floor(r * p / 100) is tested as 100 * x > r * p.
    localparam int PCT_DIV   = 100;
    localparam int PROD_W    = $clog2((2**ET_W - 1) * (2**PCT_W - 1) + 1);
    localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(10);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOWER_ACT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EG_MISC   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_MISC  = CFG_IDX_W'(2);

    // One tower as it arrives.
    typedef struct packed {
        logic [ET_W-1:0]  tower_et;
        logic [ET_W-1:0]  ecal_et;
        logic [ET_W-1:0]  region_et;
        logic [IDX_W-1:0] tower_eta;
        logic [IDX_W-1:0] tower_phi;
        logic             is_central;
        logic             last_tower;
    } t_item;

    // One tower with its scaled thresholds, entering the accumulators.
    typedef struct packed {
        logic              vld;
        t_item             item;
        logic [PROD_W-1:0] tower_x100;
        logic [PROD_W-1:0] act_prod;
        logic [PROD_W-1:0] eg_prod;
        logic [PROD_W-1:0] tau_prod;
    } t_stage;

    // Closed region, handed to the veto stage.
    typedef struct packed {
        logic               vld;
        logic               is_central;
        logic [ET_W-1:0]    region_et;
        logic [PROD_W-1:0]  eg_prod;
        logic [PROD_W-1:0]  tau_prod;
        logic [SUM_W-1:0]   ecal_sum;
        logic [SUM_W-1:0]   active_sum;
        logic [CNT_W-1:0]   active_count;
        logic [POS_W-1:0]   highest_location;
        logic [STRIP_W-1:0] eta_strips;
        logic [STRIP_W-1:0] phi_strips;
    } t_snap;

    // A strip pattern that is scattered or wider than two strips.
    function automatic logic bad_pattern(input logic [STRIP_W-1:0] p);
        logic bad;
        case (p) inside
            4'b0101, 4'b0111, 4'b1001, 4'b1010,
            4'b1011, 4'b1101, 4'b1110, 4'b1111: bad = 1'b1;
            default:                            bad = 1'b0;
        endcase
        return bad;
    endfunction

endpackage

// ----- rtl/calo_region_veto_bits.sv -----
// calo_region_veto_bits: top level of the region veto block.
// Depends on crvb_pkg, crvb_front, crvb_accum, crvb_result, assert_macros.svh.
//
// Usage:
// - Towers of a 4x4 region enter one per item on start while busy is low.
//   Each item carries tower ET, ECAL ET, region ET, eta/phi position, the
//   central flag and a last-tower flag. The item with last_tower high closes
//   the region; is_central and region ET of that item drive the vetoes.
// - The block takes one tower every clock cycle while busy is low. busy is
//   high only during reset and the cycle after it.
// - One result per region appears on o_valid for exactly one cycle once the
//   last tower has passed four registers: input register, threshold
//   products, accumulators, veto register. The receiver cannot stall it.
// - Three percent registers are written over the configuration channel (i_cfg_valid /
//   o_cfg_ready, index and data); the user must write them only while no region is
//   open, the block does not enforce it. Unknown indexes are ignored. Reset loads 10 into each.
// - Synchronous reset clears the pipeline and all region accumulators.
`include "assert_macros.svh"
module calo_region_veto_bits import crvb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ET_W-1:0]      i_tower_et,
    input  logic [ET_W-1:0]      i_ecal_et,
    input  logic [ET_W-1:0]      i_region_et,
    input  logic [IDX_W-1:0]     i_tower_eta,
    input  logic [IDX_W-1:0]     i_tower_phi,
    input  logic                 i_is_central,
    input  logic                 i_last_tower,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PCT_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic                 o_eg_veto,
    output logic                 o_tau_veto,
    output logic                 o_shape_veto,
    output logic [POS_W-1:0]     o_highest_location,
    output logic [CNT_W-1:0]     o_active_count,
    output logic [STRIP_W-1:0]   o_eta_strips,
    output logic [STRIP_W-1:0]   o_phi_strips
);

    logic             r_busy;
    logic [PCT_W-1:0] r_act_pct, r_eg_pct, r_tau_pct;
    logic             accept;
    t_item            item;
    t_stage           stage;
    t_snap            snap;

    // Held busy through reset and released in the cycle after reset ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign accept      = start && !r_busy;

    // Percent registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_pct <= PCT_RESET;
            r_eg_pct  <= PCT_RESET;
            r_tau_pct <= PCT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOWER_ACT: r_act_pct <= i_cfg_data;
                CFG_EG_MISC:   r_eg_pct  <= i_cfg_data;
                CFG_TAU_MISC:  r_tau_pct <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Gather the input ports into one item.
    always_comb begin
        item.tower_et   = i_tower_et;
        item.ecal_et    = i_ecal_et;
        item.region_et  = i_region_et;
        item.tower_eta  = i_tower_eta;
        item.tower_phi  = i_tower_phi;
        item.is_central = i_is_central;
        item.last_tower = i_last_tower;
    end

    crvb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (item),
        .i_act_pct (r_act_pct),
        .i_eg_pct  (r_eg_pct),
        .i_tau_pct (r_tau_pct),
        .o_stage   (stage)
    );

    crvb_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_snap  (snap)
    );

    crvb_result u_result (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_snap             (snap),
        .o_valid            (o_valid),
        .o_eg_veto          (o_eg_veto),
        .o_tau_veto         (o_tau_veto),
        .o_shape_veto       (o_shape_veto),
        .o_highest_location (o_highest_location),
        .o_active_count     (o_active_count),
        .o_eta_strips       (o_eta_strips),
        .o_phi_strips       (o_phi_strips)
    );

    // Every result follows an accepted last tower.
    `CRVB_ASSERT(a_result_latency, i_clk, i_rst_n,
        o_valid |-> $past(start && !busy && i_last_tower, 4))

endmodule

// ----- rtl/crvb_front.sv -----
// crvb_front: input register and threshold products for each tower.
// Depends on crvb_pkg.
module crvb_front import crvb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_item            i_item,
    input  logic [PCT_W-1:0] i_act_pct,
    input  logic [PCT_W-1:0] i_eg_pct,
    input  logic [PCT_W-1:0] i_tau_pct,
    output t_stage           o_stage
);

    logic   r_s1_vld;
    t_item  r_s1;
    t_stage r_stage;
    t_stage n_stage;

    // Capture the accepted tower.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
        end
        if (i_accept) begin
            r_s1 <= i_item;
        end
    end

    // Scale the tower by 100 and region ET by each percent setting.
    always_comb begin
        n_stage.vld        = r_s1_vld;
        n_stage.item       = r_s1;
        n_stage.tower_x100 = PROD_W'(r_s1.tower_et) * PROD_W'(PCT_DIV);
        n_stage.act_prod   = PROD_W'(r_s1.region_et) * PROD_W'(i_act_pct);
        n_stage.eg_prod    = PROD_W'(r_s1.region_et) * PROD_W'(i_eg_pct);
        n_stage.tau_prod   = PROD_W'(r_s1.region_et) * PROD_W'(i_tau_pct);
    end

    // Products register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage.vld <= n_stage.vld;
        end
        r_stage.item       <= n_stage.item;
        r_stage.tower_x100 <= n_stage.tower_x100;
        r_stage.act_prod   <= n_stage.act_prod;
        r_stage.eg_prod    <= n_stage.eg_prod;
        r_stage.tau_prod   <= n_stage.tau_prod;
    end

    assign o_stage = r_stage;

endmodule

// ----- rtl/crvb_accum.sv -----
// crvb_accum: per-region accumulators (sums, count, strips, highest tower).
// Depends on crvb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crvb_accum import crvb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_snap  o_snap
);

    logic [SUM_W-1:0]   r_ecal_sum,   n_ecal_sum;
    logic [SUM_W-1:0]   r_active_sum, n_active_sum;
    logic [CNT_W-1:0]   r_act_cnt,    n_act_cnt;
    logic [ET_W-1:0]    r_max_et,     n_max_et;
    logic [POS_W-1:0]   r_max_pos,    n_max_pos;
    logic [STRIP_W-1:0] r_eta_mask,   n_eta_mask;
    logic [STRIP_W-1:0] r_phi_mask,   n_phi_mask;
    t_snap              r_snap;

    logic               active;
    logic [ADD_W-1:0]   ecal_add;
    logic [ADD_W-1:0]   act_add;

    // Update the running values with the current tower.
    always_comb begin
        active   = i_stage.tower_x100 > i_stage.act_prod;
        ecal_add = ADD_W'(r_ecal_sum) + ADD_W'(i_stage.item.ecal_et);
        act_add  = ADD_W'(r_active_sum) + ADD_W'(i_stage.item.tower_et);

        n_ecal_sum   = (ecal_add > ADD_W'(ET_LIMIT)) ? SUM_W'(ET_LIMIT)
                                                     : ecal_add[SUM_W-1:0];
        n_active_sum = r_active_sum;
        n_act_cnt    = r_act_cnt;
        n_eta_mask   = r_eta_mask;
        n_phi_mask   = r_phi_mask;
        if (active) begin
            n_active_sum = (act_add > ADD_W'(ET_LIMIT)) ? SUM_W'(ET_LIMIT)
                                                       : act_add[SUM_W-1:0];
            if (r_act_cnt != CNT_W'(CNT_MAX)) begin
                n_act_cnt = r_act_cnt + CNT_W'(1);
            end
            n_eta_mask[i_stage.item.tower_eta] = 1'b1;
            n_phi_mask[i_stage.item.tower_phi] = 1'b1;
        end

        // First strict maximum wins.
        n_max_et  = r_max_et;
        n_max_pos = r_max_pos;
        if (i_stage.item.tower_et > r_max_et) begin
            n_max_et  = i_stage.item.tower_et;
            n_max_pos = {i_stage.item.tower_eta, i_stage.item.tower_phi};
        end
    end

    // Accumulators: cleared once the last tower of a region is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecal_sum   <= '0;
            r_active_sum <= '0;
            r_act_cnt    <= '0;
            r_max_et     <= '0;
            r_max_pos    <= '0;
            r_eta_mask   <= '0;
            r_phi_mask   <= '0;
        end else if (i_stage.vld) begin
            if (i_stage.item.last_tower) begin
                r_ecal_sum   <= '0;
                r_active_sum <= '0;
                r_act_cnt    <= '0;
                r_max_et     <= '0;
                r_max_pos    <= '0;
                r_eta_mask   <= '0;
                r_phi_mask   <= '0;
            end else begin
                r_ecal_sum   <= n_ecal_sum;
                r_active_sum <= n_active_sum;
                r_act_cnt    <= n_act_cnt;
                r_max_et     <= n_max_et;
                r_max_pos    <= n_max_pos;
                r_eta_mask   <= n_eta_mask;
                r_phi_mask   <= n_phi_mask;
            end
        end
    end

    // Snapshot of the closed region for the veto stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap.vld <= 1'b0;
        end else begin
            r_snap.vld <= i_stage.vld && i_stage.item.last_tower;
        end
        r_snap.is_central       <= i_stage.item.is_central;
        r_snap.region_et        <= i_stage.item.region_et;
        r_snap.eg_prod          <= i_stage.eg_prod;
        r_snap.tau_prod         <= i_stage.tau_prod;
        r_snap.ecal_sum         <= n_ecal_sum;
        r_snap.active_sum       <= n_active_sum;
        r_snap.active_count     <= n_act_cnt;
        r_snap.highest_location <= n_max_pos;
        r_snap.eta_strips       <= n_eta_mask;
        r_snap.phi_strips       <= n_phi_mask;
    end

    assign o_snap = r_snap;

    // A region closes only on a last tower, and the accumulators restart.
    `CRVB_ASSERT(a_snap_from_last, i_clk, i_rst_n,
        r_snap.vld |-> $past(i_stage.vld && i_stage.item.last_tower))
    `CRVB_ASSERT(a_clear_after_last, i_clk, i_rst_n,
        (i_stage.vld && i_stage.item.last_tower) |=>
            (r_act_cnt == '0 && r_ecal_sum == '0 && r_eta_mask == '0))
    `CRVB_NEVER(a_sum_limit, i_clk, i_rst_n,
        (ADD_W'(r_ecal_sum) > ADD_W'(ET_LIMIT)) ||
        (ADD_W'(r_active_sum) > ADD_W'(ET_LIMIT)))

endmodule

// ----- rtl/crvb_result.sv -----
// crvb_result: shape, EG and tau vetoes and the result register.
// Depends on crvb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crvb_result import crvb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_snap              i_snap,
    output logic               o_valid,
    output logic               o_eg_veto,
    output logic               o_tau_veto,
    output logic               o_shape_veto,
    output logic [POS_W-1:0]   o_highest_location,
    output logic [CNT_W-1:0]   o_active_count,
    output logic [STRIP_W-1:0] o_eta_strips,
    output logic [STRIP_W-1:0] o_phi_strips
);

    logic               r_valid;
    logic               r_eg_veto, r_tau_veto, r_shape_veto;
    logic [POS_W-1:0]   r_highest_location;
    logic [CNT_W-1:0]   r_active_count;
    logic [STRIP_W-1:0] r_eta_strips, r_phi_strips;

    logic               shape;
    logic               ecal_over, act_over;
    logic [ET_W-1:0]    ecal_diff, act_diff;
    logic [PROD_W-1:0]  ecal_x100, act_x100;
    logic               n_eg, n_tau, n_shape;

    // In a central region, a sum above region ET counts as a huge remainder and vetoes.
    always_comb begin
        shape     = bad_pattern(i_snap.eta_strips) || bad_pattern(i_snap.phi_strips);
        ecal_over = ADD_W'(i_snap.ecal_sum) > ADD_W'(i_snap.region_et);
        act_over  = ADD_W'(i_snap.active_sum) > ADD_W'(i_snap.region_et);
        ecal_diff = i_snap.region_et - ET_W'(i_snap.ecal_sum);
        act_diff  = i_snap.region_et - ET_W'(i_snap.active_sum);
        ecal_x100 = PROD_W'(ecal_diff) * PROD_W'(PCT_DIV);
        act_x100  = PROD_W'(act_diff) * PROD_W'(PCT_DIV);

        n_shape = 1'b0;
        n_eg    = 1'b0;
        n_tau   = 1'b0;
        if (i_snap.is_central) begin
            n_shape = shape;
            n_eg    = shape || ecal_over || (ecal_x100 > i_snap.eg_prod);
            n_tau   = shape || act_over || (act_x100 > i_snap.tau_prod);
        end
    end

    // Result register; the strobe lasts one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_snap.vld;
        end
        r_eg_veto          <= n_eg;
        r_tau_veto         <= n_tau;
        r_shape_veto       <= n_shape;
        r_highest_location <= i_snap.highest_location;
        r_active_count     <= i_snap.active_count;
        r_eta_strips       <= i_snap.eta_strips;
        r_phi_strips       <= i_snap.phi_strips;
    end

    assign o_valid            = r_valid;
    assign o_eg_veto          = r_eg_veto;
    assign o_tau_veto         = r_tau_veto;
    assign o_shape_veto       = r_shape_veto;
    assign o_highest_location = r_highest_location;
    assign o_active_count     = r_active_count;
    assign o_eta_strips       = r_eta_strips;
    assign o_phi_strips       = r_phi_strips;

    // A shape veto always carries both other vetoes.
    `CRVB_ASSERT(a_shape_implies_vetoes, i_clk, i_rst_n,
        (r_valid && r_shape_veto) |-> (r_eg_veto && r_tau_veto))

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for calo_region_veto_bits. It streams regions of towers
// through a random-gap driver and checks every region result against a predictor kept here.
// Depends on crvb_pkg and the calo_region_veto_bits RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crvb_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 64;
    localparam int MAX_REGION   = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    // One region result as the block reports it.
    typedef struct packed {
        logic               eg_veto;
        logic               tau_veto;
        logic               shape_veto;
        logic [POS_W-1:0]   highest_location;
        logic [CNT_W-1:0]   active_count;
        logic [STRIP_W-1:0] eta_strips;
        logic [STRIP_W-1:0] phi_strips;
    } t_region_bits;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [ET_W-1:0]      i_tower_et = '0;
    logic [ET_W-1:0]      i_ecal_et = '0;
    logic [ET_W-1:0]      i_region_et = '0;
    logic [IDX_W-1:0]     i_tower_eta = '0;
    logic [IDX_W-1:0]     i_tower_phi = '0;
    logic                 i_is_central = 1'b0;
    logic                 i_last_tower = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PCT_W-1:0]     i_cfg_data = '0;
    logic                 o_valid;
    logic                 o_eg_veto;
    logic                 o_tau_veto;
    logic                 o_shape_veto;
    logic [POS_W-1:0]     o_highest_location;
    logic [CNT_W-1:0]     o_active_count;
    logic [STRIP_W-1:0]   o_eta_strips;
    logic [STRIP_W-1:0]   o_phi_strips;

    calo_region_veto_bits dut (.*);

    // Towers waiting to be sent and region results waiting to arrive.
    t_item        tower_q[$];
    t_region_bits region_bits_q[$];

    int unsigned towers_pushed = 0;
    int unsigned towers_taken  = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned err_cnt       = 0;
    int unsigned hold_off      = 0;
    bit          quiet         = 1'b0;
    logic        tower_taken   = 1'b0;
    logic        cfg_taken     = 1'b0;

    // Predictor copy of the percent registers and the region accumulators.
    logic [PCT_W-1:0]   act_pct  = PCT_RESET;
    logic [PCT_W-1:0]   eg_pct   = PCT_RESET;
    logic [PCT_W-1:0]   tau_pct  = PCT_RESET;
    logic [SUM_W-1:0]   ecal_acc = '0;
    logic [SUM_W-1:0]   act_acc  = '0;
    logic [CNT_W-1:0]   act_cnt  = '0;
    logic [ET_W-1:0]    peak_et  = '0;
    logic [POS_W-1:0]   peak_pos = '0;
    logic [STRIP_W-1:0] eta_m    = '0;
    logic [STRIP_W-1:0] phi_m    = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor of a percentage of an ET value.
    function automatic int unsigned pct_floor(input logic [ET_W-1:0] et,
                                              input logic [PCT_W-1:0] pct);
        return (32'(et) * 32'(pct)) / PCT_DIV;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                 input logic [ET_W-1:0] add);
        int unsigned s;
        s = 32'(acc) + 32'(add);
        return (s > ET_LIMIT) ? SUM_W'(ET_LIMIT) : SUM_W'(s);
    endfunction

    // A strip pattern is compact when it is empty, one strip, or two neighboring strips.
    function automatic bit strips_spread(input logic [STRIP_W-1:0] m);
        return !($countones(m) <= 1 || ($countones(m) == 2 && (m & (m >> 1)) != '0));
    endfunction

    // Fold one accepted tower into the accumulators; a last tower closes the region.
    task automatic absorb_tower(input t_item t);
        t_region_bits res;
        bit shape;
        ecal_acc = sat_sum(ecal_acc, t.ecal_et);
        if (32'(t.tower_et) > pct_floor(t.region_et, act_pct)) begin
            if (act_cnt < CNT_W'(CNT_MAX))
                act_cnt = act_cnt + CNT_W'(1);
            act_acc = sat_sum(act_acc, t.tower_et);
            eta_m[t.tower_eta] = 1'b1;
            phi_m[t.tower_phi] = 1'b1;
        end
        if (t.tower_et > peak_et) begin
            peak_et  = t.tower_et;
            peak_pos = {t.tower_eta, t.tower_phi};
        end
        if (t.last_tower) begin
            res = '0;
            if (t.is_central) begin
                shape = strips_spread(eta_m) || strips_spread(phi_m);
                res.shape_veto = shape;
                res.eg_veto = shape || 32'(ecal_acc) > 32'(t.region_et) ||
                    (32'(t.region_et) - 32'(ecal_acc)) > pct_floor(t.region_et, eg_pct);
                res.tau_veto = shape || 32'(act_acc) > 32'(t.region_et) ||
                    (32'(t.region_et) - 32'(act_acc)) > pct_floor(t.region_et, tau_pct);
            end
            res.highest_location = peak_pos;
            res.active_count     = act_cnt;
            res.eta_strips       = eta_m;
            res.phi_strips       = phi_m;
            region_bits_q.push_back(res);
            ecal_acc = '0;
            act_acc  = '0;
            act_cnt  = '0;
            peak_et  = '0;
            peak_pos = '0;
            eta_m    = '0;
            phi_m    = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Driver: a new item goes out at the falling edge once the last one was taken and any random gap is over.
    always @(negedge i_clk) begin : feed
        t_item nxt;
        if (start && !tower_taken) begin
            // Item still waiting for the block.
        end else if (hold_off != 0) begin
            start    <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (tower_q.size() != 0) begin
            nxt = tower_q.pop_front();
            start        <= 1'b1;
            i_tower_et   <= nxt.tower_et;
            i_ecal_et    <= nxt.ecal_et;
            i_region_et  <= nxt.region_et;
            i_tower_eta  <= nxt.tower_eta;
            i_tower_phi  <= nxt.tower_phi;
            i_is_central <= nxt.is_central;
            i_last_tower <= nxt.last_tower;
            hold_off     <= quiet ? 0 : $urandom_range(0, 9);
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: handshakes, predictor updates and result checks at the rising edge.
    always @(posedge i_clk) begin : watch
        t_region_bits want;
        t_item cur;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end else begin
            tower_taken <= start && !busy;
            cfg_taken   <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOWER_ACT: act_pct = i_cfg_data;
                    CFG_EG_MISC:   eg_pct  = i_cfg_data;
                    CFG_TAU_MISC:  tau_pct = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid === 1'b1) begin
                if (region_bits_q.size() == 0) begin
                    $display("%0t: result with none expected", $time);
                    err_cnt++;
                end else begin
                    want = region_bits_q.pop_front();
                    check_field("eg_veto", 32'(want.eg_veto), 32'(o_eg_veto));
                    check_field("tau_veto", 32'(want.tau_veto), 32'(o_tau_veto));
                    check_field("shape_veto", 32'(want.shape_veto), 32'(o_shape_veto));
                    check_field("highest_location", 32'(want.highest_location),
                                32'(o_highest_location));
                    check_field("active_count", 32'(want.active_count),
                                32'(o_active_count));
                    check_field("eta_strips", 32'(want.eta_strips), 32'(o_eta_strips));
                    check_field("phi_strips", 32'(want.phi_strips), 32'(o_phi_strips));
                end
            end
            if (start && !busy) begin
                cur = '{i_tower_et, i_ecal_et, i_region_et, i_tower_eta, i_tower_phi,
                        i_is_central, i_last_tower};
                absorb_tower(cur);
                towers_taken++;
            end
        end
    end

    task automatic push_tower(input int unsigned et, input int unsigned ecal,
                              input int unsigned rgn, input int unsigned eta,
                              input int unsigned phi, input bit central, input bit last);
        t_item t;
        t.tower_et   = ET_W'(et);
        t.ecal_et    = ET_W'(ecal);
        t.region_et  = ET_W'(rgn);
        t.tower_eta  = IDX_W'(eta);
        t.tower_phi  = IDX_W'(phi);
        t.is_central = central;
        t.last_tower = last;
        tower_q.push_back(t);
        towers_pushed++;
    endtask

    // Queue one region of n towers. A shaped region has a compact core of hot towers,
    // a sprinkle of low noise, now and then a stray hot tower, and region ET near the
    // tower sum. Otherwise the ET fields and the central flag are random.
    task automatic queue_region(input int unsigned n, input bit shaped);
        int unsigned et_v[MAX_REGION];
        int unsigned ecal_v[MAX_REGION];
        int unsigned rgn_v[MAX_REGION];
        bit          ctr_v[MAX_REGION];
        int unsigned e0, ew, p0, pw, k, total, r, eta, phi;
        bit central, in_core;
        e0 = $urandom_range(0, 3);
        ew = (e0 == 3) ? 1 : $urandom_range(1, 2);
        p0 = $urandom_range(0, 3);
        pw = (p0 == 3) ? 1 : $urandom_range(1, 2);
        central = ($urandom_range(0, 3) != 0);
        total = 0;
        for (k = 0; k < n; k++) begin
            eta = (k >> 2) % 4;
            phi = k % 4;
            if (shaped) begin
                in_core = eta >= e0 && eta < e0 + ew && phi >= p0 && phi < p0 + pw;
                if (in_core)
                    et_v[k] = $urandom_range(20, 250);
                else if ($urandom_range(0, 30) == 0)
                    et_v[k] = $urandom_range(50, 300);
                else if ($urandom_range(0, 4) == 0)
                    et_v[k] = $urandom_range(1, 6);
                else
                    et_v[k] = 0;
                ecal_v[k] = et_v[k] - $urandom_range(0, et_v[k] / 10);
                ctr_v[k]  = central;
                total += et_v[k];
            end else begin
                et_v[k]   = $urandom_range(0, 1023);
                ecal_v[k] = $urandom_range(0, 1023);
                rgn_v[k]  = $urandom_range(0, 1023);
                ctr_v[k]  = 1'($urandom_range(0, 1));
            end
        end
        if (shaped) begin
            r = total + $urandom_range(0, 40);
            if (r > 1023)
                r = 1023;
            for (k = 0; k < n; k++)
                rgn_v[k] = r;
        end
        for (k = 0; k < n; k++)
            push_tower(et_v[k], ecal_v[k], rgn_v[k], (k >> 2) % 4, k % 4, ctr_v[k],
                       k == n - 1);
    endtask

    task automatic write_pct_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [PCT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_pct(input logic [PCT_W-1:0] act, input logic [PCT_W-1:0] eg,
                                 input logic [PCT_W-1:0] tau);
        write_pct_reg(CFG_TOWER_ACT, act);
        write_pct_reg(CFG_EG_MISC, eg);
        write_pct_reg(CFG_TAU_MISC, tau);
    endtask

    function automatic logic [PCT_W-1:0] draw_pct();
        return PCT_W'($urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(0, 127));
    endfunction

    // Wait until every tower is taken and every region result is back, then let the
    // pipeline settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (towers_taken != towers_pushed || region_bits_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Stimulus: directed regions first, then phases of random regions under
    // different percent settings.
    initial begin
        int unsigned ph, phase_start, pick;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-tower region with every field at its maximum.
        push_tower(1023, 1023, 1023, 3, 3, 1, 1);
        // All-zero non-central region of one tower.
        push_tower(0, 0, 0, 0, 0, 0, 1);
        // Both sums saturate and exceed region ET, so both vetoes fire.
        push_tower(600, 1023, 300, 0, 1, 1, 0);
        push_tower(600, 1023, 300, 0, 2, 1, 0);
        push_tower(10, 5, 300, 1, 1, 1, 1);
        // Scattered strips in a non-central region: no vetoes. Tied peak keeps the first.
        push_tower(200, 200, 400, 0, 0, 0, 0);
        push_tower(200, 200, 400, 2, 0, 0, 0);
        push_tower(200, 200, 400, 0, 3, 0, 0);
        push_tower(0, 0, 400, 1, 1, 0, 1);
        // Clean central cluster, with a tower and both sums exactly at their thresholds.
        push_tower(300, 260, 400, 1, 1, 1, 0);
        push_tower(60, 60, 400, 1, 2, 1, 0);
        push_tower(40, 40, 400, 2, 1, 1, 0);
        push_tower(0, 0, 400, 3, 3, 1, 1);
        wait_drained();

        for (ph = 1; ph < PHASES; ph++) begin
            case (ph)
                1: write_all_pct(0, 0, 0);
                2: begin
                    write_all_pct(127, 127, 127);
                    write_pct_reg(CFG_UNUSED, 55);
                end
                3: write_all_pct(100, 100, 100);
                default: write_all_pct(draw_pct(), draw_pct(), draw_pct());
            endcase
            quiet = (ph == 3 || ph == 6);
            phase_start = towers_pushed;
            // With a zero threshold a long run drives the active count into saturation.
            if (ph == 1)
                queue_region(40, 1'b0);
            while (towers_pushed - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick <= 6)
                    queue_region(16, 1'b1);
                else if (pick == 7)
                    queue_region(16, 1'b0);
                else if (pick == 8)
                    queue_region($urandom_range(1, 24), 1'b1);
                else
                    queue_region($urandom_range(1, 40), 1'b0);
            end
            wait_drained();
        end

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/crvb_pkg.sv
rtl/crvb_front.sv
rtl/crvb_accum.sv
rtl/crvb_result.sv
rtl/calo_region_veto_bits.sv
test/tb.sv
